/* design/vkst_pkg.sv */
package vkst_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int LATCH_W    = 4;
  localparam int LEVEL_IN_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ADC_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADC_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LVL = 3'd4;

  localparam int HYST_RESET = 32;
  localparam logic [LATCH_W-1:0] WINDOW_RESET = 4'd1;

  typedef struct packed {
    logic load;
    logic acc;
    logic smooth_ld;
    logic clamp;
    logic cand_ld;
    logic qual;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic div_busy;
    logic need_div;
  } dp_sts_t;

endpackage

/* design/vkst_div.sv */
module vkst_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      quo_nxt  = num;
    end else if (busy_r) begin
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = cnt_r != CNT_W'(1);
      rem_nxt  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_nxt  = {quo_r[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

/* design/vkst_dp.sv */
module vkst_dp #(
  parameter int AVG_DEPTH   = 8,
  parameter int MAX_LEVEL   = 9,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  vkst_pkg::dp_cmd_t                  cmd,
  output vkst_pkg::dp_sts_t                  sts,
  input  logic                               in_mode,
  input  logic [SAMPLE_BITS-1:0]             in_sample,
  input  logic [vkst_pkg::LEVEL_IN_W-1:0]    in_level,
  input  logic                               cfg_we,
  input  logic [vkst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [SAMPLE_BITS-1:0]             cfg_data,
  output logic                               out_volume_write,
  output logic [$clog2(MAX_LEVEL+1)-1:0]     out_volume,
  output logic                               out_knob_latched,
  output logic [$clog2(MAX_LEVEL+1)-1:0]     out_knob_step,
  output logic [SAMPLE_BITS-1:0]             out_smoothed
);

  localparam int SB     = SAMPLE_BITS;
  localparam int LVL_W  = $clog2(MAX_LEVEL + 1);
  localparam int SUM_W  = SB + $clog2(AVG_DEPTH);
  localparam int FILL_W = $clog2(AVG_DEPTH + 1);
  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int STEP_W = SB + LVL_W;
  localparam int NUM_W  = (SUM_W > STEP_W) ? SUM_W : STEP_W;
  localparam int CMP_W  = 8;
  localparam int LW     = vkst_pkg::LATCH_W;

  localparam logic [LVL_W-1:0]  MAX_LVL = LVL_W'(MAX_LEVEL);
  localparam logic [FILL_W-1:0] FULL    = FILL_W'(AVG_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SL = SLOT_W'(AVG_DEPTH - 1);

  // configuration
  logic [SB-1:0]    low_r, high_r, hyst_r;
  logic [LW-1:0]    win_r;
  logic [LVL_W-1:0] init_sat;

  // averager
  logic [SB-1:0]     ring_m [AVG_DEPTH];
  logic [SB-1:0]     old_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SLOT_W-1:0] slot_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              full;

  // captured word
  logic                         mode_r;
  logic [SB-1:0]                samp_r;
  logic [vkst_pkg::LEVEL_IN_W-1:0] lvl_r;

  // step and knob state
  logic [SB-1:0]    smooth_r, stable_r;
  logic [LVL_W-1:0] cand_r, last_r, actual_r;
  logic             latched_r, wr_r;

  logic             at_low, at_high;
  logic [SB-1:0]    span, rel, hdiff;
  logic [STEP_W-1:0] step_num;
  logic             div_start, div_busy;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [SB-1:0]    div_den;
  logic [LVL_W-1:0] quo_sat, lvl_sat, q_step, ldiff;
  logic             hyst_hold, upd_stable, lat_nxt, wr_nxt;

  always_comb begin
    full     = fill_r == FULL;
    sum_nxt  = sum_r - (full ? SUM_W'(old_r) : '0) + SUM_W'(samp_r);
    fill_nxt = full ? fill_r : fill_r + FILL_W'(1);

    at_low   = smooth_r <= low_r;
    at_high  = smooth_r >= high_r;
    span     = high_r - low_r;
    rel      = smooth_r - low_r;
    step_num = STEP_W'(rel) * STEP_W'(MAX_LEVEL + 1);

    div_start = cmd.acc || (cmd.clamp && !at_low && !at_high);
    div_num   = cmd.acc ? NUM_W'(sum_nxt) : NUM_W'(step_num);
    div_den   = cmd.acc ? SB'(fill_nxt) : span;

    quo_sat = (div_quo > NUM_W'(MAX_LEVEL)) ? MAX_LVL : div_quo[LVL_W-1:0];
    lvl_sat = (lvl_r > 8'(MAX_LEVEL)) ? MAX_LVL : LVL_W'(lvl_r);
    init_sat = ({4'b0, cfg_data[LW-1:0]} > 8'(MAX_LEVEL)) ? MAX_LVL
                                                         : LVL_W'(cfg_data[LW-1:0]);

    // hysteresis
    hdiff      = (smooth_r >= stable_r) ? smooth_r - stable_r : stable_r - smooth_r;
    hyst_hold  = (cand_r != last_r) && (hdiff < hyst_r);
    upd_stable = !hyst_hold;
    q_step     = hyst_hold ? last_r : cand_r;

    // soft takeover
    ldiff   = (q_step >= actual_r) ? q_step - actual_r : actual_r - q_step;
    lat_nxt = latched_r || (CMP_W'(ldiff) <= CMP_W'(win_r));
    wr_nxt  = lat_nxt && (q_step != actual_r);
  end

  vkst_div #(
    .NUM_W (NUM_W),
    .DEN_W (SB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      old_r <= ring_m[slot_r];
    end
    if (cmd.acc) begin
      ring_m[slot_r] <= samp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r     <= '0;
      high_r    <= '1;
      hyst_r    <= SB'(vkst_pkg::HYST_RESET);
      win_r     <= vkst_pkg::WINDOW_RESET;
      sum_r     <= '0;
      slot_r    <= '0;
      fill_r    <= '0;
      stable_r  <= '0;
      last_r    <= '0;
      actual_r  <= '0;
      latched_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          vkst_pkg::CFG_ADC_LOW:  low_r  <= cfg_data;
          vkst_pkg::CFG_ADC_HIGH: high_r <= cfg_data;
          vkst_pkg::CFG_HYST:     hyst_r <= cfg_data;
          vkst_pkg::CFG_WINDOW:   win_r  <= cfg_data[LW-1:0];
          vkst_pkg::CFG_INIT_LVL: begin
            last_r   <= init_sat;
            actual_r <= init_sat;
          end
          default: ;
        endcase
      end
      if (cmd.acc) begin
        sum_r  <= sum_nxt;
        fill_r <= fill_nxt;
        slot_r <= (slot_r == LAST_SL) ? '0 : slot_r + SLOT_W'(1);
      end
      if (cmd.qual) begin
        last_r    <= q_step;
        latched_r <= lat_nxt;
        if (upd_stable) begin
          stable_r <= smooth_r;
        end
        if (wr_nxt) begin
          actual_r <= q_step;
        end
      end
      if (cmd.fin && mode_r) begin
        actual_r  <= lvl_sat;
        latched_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      samp_r <= in_sample;
      lvl_r  <= in_level;
    end
    if (cmd.smooth_ld) begin
      smooth_r <= div_quo[SB-1:0];
    end
    if (cmd.clamp && at_low) begin
      cand_r <= '0;
    end else if (cmd.clamp && at_high) begin
      cand_r <= MAX_LVL;
    end else if (cmd.cand_ld) begin
      cand_r <= quo_sat;
    end
    if (cmd.qual) begin
      wr_r <= wr_nxt;
    end
    if (cmd.fin) begin
      out_volume_write <= mode_r ? 1'b0 : wr_r;
      out_volume       <= mode_r ? lvl_sat : actual_r;
      out_knob_latched <= mode_r ? 1'b0 : latched_r;
      out_knob_step    <= last_r;
      out_smoothed     <= mode_r ? '0 : smooth_r;
    end
  end

  assign sts.mode     = mode_r;
  assign sts.div_busy = div_busy;
  assign sts.need_div = !at_low && !at_high;

  a_actual_range: assert property (@(posedge clk) disable iff (!rst_n)
    actual_r <= MAX_LVL)
    else $error("actual volume above max level");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    last_r <= MAX_LVL)
    else $error("knob step above max level");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL)
    else $error("fill count above window depth");

endmodule

/* design/vkst_ctrl.sv */
module vkst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output vkst_pkg::dp_cmd_t cmd,
  input  vkst_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DIV_AVG,
    S_CLAMP,
    S_DIV_STEP,
    S_QUAL,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fin_go;

  always_comb begin
    fin_go = (state_r == S_FIN) && (!out_valid_r || !out_stall);

    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.acc       = (state_r == S_ACC) && !sts.mode;
    cmd.smooth_ld = (state_r == S_DIV_AVG) && !sts.div_busy;
    cmd.clamp     = state_r == S_CLAMP;
    cmd.cand_ld   = (state_r == S_DIV_STEP) && !sts.div_busy;
    cmd.qual      = state_r == S_QUAL;
    cmd.fin       = fin_go;

    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_ACC;
      S_ACC:      state_nxt = sts.mode ? S_FIN : S_DIV_AVG;
      S_DIV_AVG:  if (!sts.div_busy) state_nxt = S_CLAMP;
      S_CLAMP:    state_nxt = sts.need_div ? S_DIV_STEP : S_QUAL;
      S_DIV_STEP: if (!sts.div_busy) state_nxt = S_QUAL;
      S_QUAL:     state_nxt = S_FIN;
      S_FIN:      if (fin_go) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  a_load_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_ACC)
    else $error("accepted word did not reach accumulate");

  a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |=> sts.div_busy)
    else $error("average division not running");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled word dropped");

endmodule

/* design/volume_knob_soft_takeover.sv */
// Volume knob with moving-average smoothing, hysteresis and soft takeover.
// A knob sample passes through a running-sum averager, then two divisions on
// one shared restoring divider that retires one quotient bit per cycle: the
// average (sum over samples held) and the step mapping over the calibrated
// span, the latter skipped when the reading lies at or outside the span. The
// divider width is the wider of SAMPLE_BITS + $clog2(AVG_DEPTH) and
// SAMPLE_BITS + $clog2(MAX_LEVEL+1) (16 by default); a volume notification
// skips the averager and both divisions. One word is processed at a time; the
// result sits in an output register, so the next word is taken while it
// waits. Register writes are always ready and are to be issued only while the
// block is idle.
module volume_knob_soft_takeover #(
  parameter int AVG_DEPTH   = 8,
  parameter int MAX_LEVEL   = 9,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [SAMPLE_BITS-1:0]            in_sample,
  input  logic [vkst_pkg::LEVEL_IN_W-1:0]   in_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_volume_write,
  output logic [$clog2(MAX_LEVEL+1)-1:0]    out_volume,
  output logic                              out_knob_latched,
  output logic [$clog2(MAX_LEVEL+1)-1:0]    out_knob_step,
  output logic [SAMPLE_BITS-1:0]            out_smoothed,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vkst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [SAMPLE_BITS-1:0]            cfg_data
);

  vkst_pkg::dp_cmd_t cmd;
  vkst_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  vkst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  vkst_dp #(
    .AVG_DEPTH   (AVG_DEPTH),
    .MAX_LEVEL   (MAX_LEVEL),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_sample        (in_sample),
    .in_level         (in_level),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_volume_write (out_volume_write),
    .out_volume       (out_volume),
    .out_knob_latched (out_knob_latched),
    .out_knob_step    (out_knob_step),
    .out_smoothed     (out_smoothed)
  );

endmodule
